FILE: hw/rtl/des_pkg.sv
// des block cipher package: permutation tables, s-boxes and key cell control type
package des_pkg;

  localparam int unsigned NumRounds = 16;

  // rounds whose key-schedule rotation is two places (one place elsewhere)
  localparam logic [NumRounds-1:0] RotTwo = 16'h7EFC;

  typedef struct packed {
    logic load;   // take the pc-1 bit
    logic step;   // advance to the rotated value
    logic shift;  // rotate in this round
    logic left;   // rotate toward the msb (encrypt)
    logic two;    // rotate by two places
  } des_kctl_t;

  localparam logic [6:0] IpMap [64] = '{
    7'd58, 7'd50, 7'd42, 7'd34, 7'd26, 7'd18, 7'd10, 7'd2,
    7'd60, 7'd52, 7'd44, 7'd36, 7'd28, 7'd20, 7'd12, 7'd4,
    7'd62, 7'd54, 7'd46, 7'd38, 7'd30, 7'd22, 7'd14, 7'd6,
    7'd64, 7'd56, 7'd48, 7'd40, 7'd32, 7'd24, 7'd16, 7'd8,
    7'd57, 7'd49, 7'd41, 7'd33, 7'd25, 7'd17, 7'd9,  7'd1,
    7'd59, 7'd51, 7'd43, 7'd35, 7'd27, 7'd19, 7'd11, 7'd3,
    7'd61, 7'd53, 7'd45, 7'd37, 7'd29, 7'd21, 7'd13, 7'd5,
    7'd63, 7'd55, 7'd47, 7'd39, 7'd31, 7'd23, 7'd15, 7'd7};

  localparam logic [6:0] IpInvMap [64] = '{
    7'd40, 7'd8, 7'd48, 7'd16, 7'd56, 7'd24, 7'd64, 7'd32,
    7'd39, 7'd7, 7'd47, 7'd15, 7'd55, 7'd23, 7'd63, 7'd31,
    7'd38, 7'd6, 7'd46, 7'd14, 7'd54, 7'd22, 7'd62, 7'd30,
    7'd37, 7'd5, 7'd45, 7'd13, 7'd53, 7'd21, 7'd61, 7'd29,
    7'd36, 7'd4, 7'd44, 7'd12, 7'd52, 7'd20, 7'd60, 7'd28,
    7'd35, 7'd3, 7'd43, 7'd11, 7'd51, 7'd19, 7'd59, 7'd27,
    7'd34, 7'd2, 7'd42, 7'd10, 7'd50, 7'd18, 7'd58, 7'd26,
    7'd33, 7'd1, 7'd41, 7'd9,  7'd49, 7'd17, 7'd57, 7'd25};

  localparam logic [6:0] EMap [48] = '{
    7'd32, 7'd1,  7'd2,  7'd3,  7'd4,  7'd5,  7'd4,  7'd5,  7'd6,  7'd7,  7'd8,  7'd9,
    7'd8,  7'd9,  7'd10, 7'd11, 7'd12, 7'd13, 7'd12, 7'd13, 7'd14, 7'd15, 7'd16, 7'd17,
    7'd16, 7'd17, 7'd18, 7'd19, 7'd20, 7'd21, 7'd20, 7'd21, 7'd22, 7'd23, 7'd24, 7'd25,
    7'd24, 7'd25, 7'd26, 7'd27, 7'd28, 7'd29, 7'd28, 7'd29, 7'd30, 7'd31, 7'd32, 7'd1};

  localparam logic [6:0] PMap [32] = '{
    7'd16, 7'd7,  7'd20, 7'd21, 7'd29, 7'd12, 7'd28, 7'd17,
    7'd1,  7'd15, 7'd23, 7'd26, 7'd5,  7'd18, 7'd31, 7'd10,
    7'd2,  7'd8,  7'd24, 7'd14, 7'd32, 7'd27, 7'd3,  7'd9,
    7'd19, 7'd13, 7'd30, 7'd6,  7'd22, 7'd11, 7'd4,  7'd25};

  localparam logic [6:0] Pc1Map [56] = '{
    7'd57, 7'd49, 7'd41, 7'd33, 7'd25, 7'd17, 7'd9,
    7'd1,  7'd58, 7'd50, 7'd42, 7'd34, 7'd26, 7'd18,
    7'd10, 7'd2,  7'd59, 7'd51, 7'd43, 7'd35, 7'd27,
    7'd19, 7'd11, 7'd3,  7'd60, 7'd52, 7'd44, 7'd36,
    7'd63, 7'd55, 7'd47, 7'd39, 7'd31, 7'd23, 7'd15,
    7'd7,  7'd62, 7'd54, 7'd46, 7'd38, 7'd30, 7'd22,
    7'd14, 7'd6,  7'd61, 7'd53, 7'd45, 7'd37, 7'd29,
    7'd21, 7'd13, 7'd5,  7'd28, 7'd20, 7'd12, 7'd4};

  localparam logic [6:0] Pc2Map [48] = '{
    7'd14, 7'd17, 7'd11, 7'd24, 7'd1,  7'd5,  7'd3,  7'd28, 7'd15, 7'd6,  7'd21, 7'd10,
    7'd23, 7'd19, 7'd12, 7'd4,  7'd26, 7'd8,  7'd16, 7'd7,  7'd27, 7'd20, 7'd13, 7'd2,
    7'd41, 7'd52, 7'd31, 7'd37, 7'd47, 7'd55, 7'd30, 7'd40, 7'd51, 7'd45, 7'd33, 7'd48,
    7'd44, 7'd49, 7'd39, 7'd56, 7'd34, 7'd53, 7'd46, 7'd42, 7'd50, 7'd36, 7'd29, 7'd32};

  localparam logic [3:0] SboxTab [8][64] = '{
    '{4'd14, 4'd4, 4'd13, 4'd1, 4'd2, 4'd15, 4'd11, 4'd8, 4'd3, 4'd10, 4'd6, 4'd12,
      4'd5, 4'd9, 4'd0, 4'd7, 4'd0, 4'd15, 4'd7, 4'd4, 4'd14, 4'd2, 4'd13, 4'd1,
      4'd10, 4'd6, 4'd12, 4'd11, 4'd9, 4'd5, 4'd3, 4'd8, 4'd4, 4'd1, 4'd14, 4'd8,
      4'd13, 4'd6, 4'd2, 4'd11, 4'd15, 4'd12, 4'd9, 4'd7, 4'd3, 4'd10, 4'd5, 4'd0,
      4'd15, 4'd12, 4'd8, 4'd2, 4'd4, 4'd9, 4'd1, 4'd7, 4'd5, 4'd11, 4'd3, 4'd14,
      4'd10, 4'd0, 4'd6, 4'd13},
    '{4'd15, 4'd1, 4'd8, 4'd14, 4'd6, 4'd11, 4'd3, 4'd4, 4'd9, 4'd7, 4'd2, 4'd13,
      4'd12, 4'd0, 4'd5, 4'd10, 4'd3, 4'd13, 4'd4, 4'd7, 4'd15, 4'd2, 4'd8, 4'd14,
      4'd12, 4'd0, 4'd1, 4'd10, 4'd6, 4'd9, 4'd11, 4'd5, 4'd0, 4'd14, 4'd7, 4'd11,
      4'd10, 4'd4, 4'd13, 4'd1, 4'd5, 4'd8, 4'd12, 4'd6, 4'd9, 4'd3, 4'd2, 4'd15,
      4'd13, 4'd8, 4'd10, 4'd1, 4'd3, 4'd15, 4'd4, 4'd2, 4'd11, 4'd6, 4'd7, 4'd12,
      4'd0, 4'd5, 4'd14, 4'd9},
    '{4'd10, 4'd0, 4'd9, 4'd14, 4'd6, 4'd3, 4'd15, 4'd5, 4'd1, 4'd13, 4'd12, 4'd7,
      4'd11, 4'd4, 4'd2, 4'd8, 4'd13, 4'd7, 4'd0, 4'd9, 4'd3, 4'd4, 4'd6, 4'd10,
      4'd2, 4'd8, 4'd5, 4'd14, 4'd12, 4'd11, 4'd15, 4'd1, 4'd13, 4'd6, 4'd4, 4'd9,
      4'd8, 4'd15, 4'd3, 4'd0, 4'd11, 4'd1, 4'd2, 4'd12, 4'd5, 4'd10, 4'd14, 4'd7,
      4'd1, 4'd10, 4'd13, 4'd0, 4'd6, 4'd9, 4'd8, 4'd7, 4'd4, 4'd15, 4'd14, 4'd3,
      4'd11, 4'd5, 4'd2, 4'd12},
    '{4'd7, 4'd13, 4'd14, 4'd3, 4'd0, 4'd6, 4'd9, 4'd10, 4'd1, 4'd2, 4'd8, 4'd5,
      4'd11, 4'd12, 4'd4, 4'd15, 4'd13, 4'd8, 4'd11, 4'd5, 4'd6, 4'd15, 4'd0, 4'd3,
      4'd4, 4'd7, 4'd2, 4'd12, 4'd1, 4'd10, 4'd14, 4'd9, 4'd10, 4'd6, 4'd9, 4'd0,
      4'd12, 4'd11, 4'd7, 4'd13, 4'd15, 4'd1, 4'd3, 4'd14, 4'd5, 4'd2, 4'd8, 4'd4,
      4'd3, 4'd15, 4'd0, 4'd6, 4'd10, 4'd1, 4'd13, 4'd8, 4'd9, 4'd4, 4'd5, 4'd11,
      4'd12, 4'd7, 4'd2, 4'd14},
    '{4'd2, 4'd12, 4'd4, 4'd1, 4'd7, 4'd10, 4'd11, 4'd6, 4'd8, 4'd5, 4'd3, 4'd15,
      4'd13, 4'd0, 4'd14, 4'd9, 4'd14, 4'd11, 4'd2, 4'd12, 4'd4, 4'd7, 4'd13, 4'd1,
      4'd5, 4'd0, 4'd15, 4'd10, 4'd3, 4'd9, 4'd8, 4'd6, 4'd4, 4'd2, 4'd1, 4'd11,
      4'd10, 4'd13, 4'd7, 4'd8, 4'd15, 4'd9, 4'd12, 4'd5, 4'd6, 4'd3, 4'd0, 4'd14,
      4'd11, 4'd8, 4'd12, 4'd7, 4'd1, 4'd14, 4'd2, 4'd13, 4'd6, 4'd15, 4'd0, 4'd9,
      4'd10, 4'd4, 4'd5, 4'd3},
    '{4'd12, 4'd1, 4'd10, 4'd15, 4'd9, 4'd2, 4'd6, 4'd8, 4'd0, 4'd13, 4'd3, 4'd4,
      4'd14, 4'd7, 4'd5, 4'd11, 4'd10, 4'd15, 4'd4, 4'd2, 4'd7, 4'd12, 4'd9, 4'd5,
      4'd6, 4'd1, 4'd13, 4'd14, 4'd0, 4'd11, 4'd3, 4'd8, 4'd9, 4'd14, 4'd15, 4'd5,
      4'd2, 4'd8, 4'd12, 4'd3, 4'd7, 4'd0, 4'd4, 4'd10, 4'd1, 4'd13, 4'd11, 4'd6,
      4'd4, 4'd3, 4'd2, 4'd12, 4'd9, 4'd5, 4'd15, 4'd10, 4'd11, 4'd14, 4'd1, 4'd7,
      4'd6, 4'd0, 4'd8, 4'd13},
    '{4'd4, 4'd11, 4'd2, 4'd14, 4'd15, 4'd0, 4'd8, 4'd13, 4'd3, 4'd12, 4'd9, 4'd7,
      4'd5, 4'd10, 4'd6, 4'd1, 4'd13, 4'd0, 4'd11, 4'd7, 4'd4, 4'd9, 4'd1, 4'd10,
      4'd14, 4'd3, 4'd5, 4'd12, 4'd2, 4'd15, 4'd8, 4'd6, 4'd1, 4'd4, 4'd11, 4'd13,
      4'd12, 4'd3, 4'd7, 4'd14, 4'd10, 4'd15, 4'd6, 4'd8, 4'd0, 4'd5, 4'd9, 4'd2,
      4'd6, 4'd11, 4'd13, 4'd8, 4'd1, 4'd4, 4'd10, 4'd7, 4'd9, 4'd5, 4'd0, 4'd15,
      4'd14, 4'd2, 4'd3, 4'd12},
    '{4'd13, 4'd2, 4'd8, 4'd4, 4'd6, 4'd15, 4'd11, 4'd1, 4'd10, 4'd9, 4'd3, 4'd14,
      4'd5, 4'd0, 4'd12, 4'd7, 4'd1, 4'd15, 4'd13, 4'd8, 4'd10, 4'd3, 4'd7, 4'd4,
      4'd12, 4'd5, 4'd6, 4'd11, 4'd0, 4'd14, 4'd9, 4'd2, 4'd7, 4'd11, 4'd4, 4'd1,
      4'd9, 4'd12, 4'd14, 4'd2, 4'd0, 4'd6, 4'd10, 4'd13, 4'd15, 4'd3, 4'd5, 4'd8,
      4'd2, 4'd1, 4'd14, 4'd7, 4'd4, 4'd10, 4'd8, 4'd13, 4'd15, 4'd12, 4'd9, 4'd0,
      4'd3, 4'd5, 4'd6, 4'd11}};

  // bit numbers in the maps count from 1 at the msb
  function automatic logic [63:0] perm_ip(input logic [63:0] x);
    logic [63:0] r;
    logic [5:0]  idx;
    r   = '0;
    idx = '0;
    for (int i = 0; i < 64; i++) begin
      idx       = 6'(7'd64 - IpMap[i]);
      r[63 - i] = x[idx];
    end
    return r;
  endfunction

  function automatic logic [63:0] perm_ip_inv(input logic [63:0] x);
    logic [63:0] r;
    logic [5:0]  idx;
    r   = '0;
    idx = '0;
    for (int i = 0; i < 64; i++) begin
      idx       = 6'(7'd64 - IpInvMap[i]);
      r[63 - i] = x[idx];
    end
    return r;
  endfunction

  function automatic logic [55:0] perm_pc1(input logic [63:0] x);
    logic [55:0] r;
    logic [5:0]  idx;
    r   = '0;
    idx = '0;
    for (int i = 0; i < 56; i++) begin
      idx       = 6'(7'd64 - Pc1Map[i]);
      r[55 - i] = x[idx];
    end
    return r;
  endfunction

  function automatic logic [47:0] perm_pc2(input logic [55:0] x);
    logic [47:0] r;
    logic [5:0]  idx;
    r   = '0;
    idx = '0;
    for (int i = 0; i < 48; i++) begin
      idx       = 6'(7'd56 - Pc2Map[i]);
      r[47 - i] = x[idx];
    end
    return r;
  endfunction

  function automatic logic [47:0] perm_e(input logic [31:0] x);
    logic [47:0] r;
    logic [4:0]  idx;
    r   = '0;
    idx = '0;
    for (int i = 0; i < 48; i++) begin
      idx       = 5'(7'd32 - EMap[i]);
      r[47 - i] = x[idx];
    end
    return r;
  endfunction

  function automatic logic [31:0] perm_p(input logic [31:0] x);
    logic [31:0] r;
    logic [4:0]  idx;
    r   = '0;
    idx = '0;
    for (int i = 0; i < 32; i++) begin
      idx       = 5'(7'd32 - PMap[i]);
      r[31 - i] = x[idx];
    end
    return r;
  endfunction

endpackage

FILE: hw/rtl/des_key_cell.sv
// one bit of the rotating key-schedule ring
module des_key_cell (
  input  logic              clk_i,
  input  des_pkg::des_kctl_t ctl_i,
  input  logic              load_bit_i,
  input  logic              lo1_i,
  input  logic              lo2_i,
  input  logic              hi1_i,
  input  logic              hi2_i,
  output logic              bit_o,
  output logic              rot_o
);
  import des_pkg::*;

  logic bit_q, bit_d;

  // rotated value used by the current round, also the next held value when the ring steps
  always_comb begin
    if (!ctl_i.shift) begin
      rot_o = bit_q;
    end else if (ctl_i.left) begin
      rot_o = ctl_i.two ? lo2_i : lo1_i;
    end else begin
      rot_o = ctl_i.two ? hi2_i : hi1_i;
    end
  end

  always_comb begin
    if (ctl_i.load) begin
      bit_d = load_bit_i;
    end else if (ctl_i.step) begin
      bit_d = rot_o;
    end else begin
      bit_d = bit_q;
    end
  end

  always_ff @(posedge clk_i) begin
    bit_q <= bit_d;
  end

  assign bit_o = bit_q;

endmodule

FILE: hw/rtl/des_round.sv
// one feistel round: expansion, subkey mix, s-boxes, p permutation
module des_round (
  input  logic [31:0] l_i,
  input  logic [31:0] r_i,
  input  logic [47:0] subkey_i,
  output logic [31:0] l_o,
  output logic [31:0] r_o
);
  import des_pkg::*;

  logic [47:0] mixed;
  logic [31:0] sbox_out;

  assign mixed = perm_e(r_i) ^ subkey_i;

  always_comb begin
    logic [5:0] six;
    six      = '0;
    sbox_out = '0;
    for (int i = 0; i < 8; i++) begin
      six = mixed[47 - 6*i -: 6];
      // row from the outer bits, column from the inner four
      sbox_out[31 - 4*i -: 4] = SboxTab[i][{six[5], six[0], six[4:1]}];
    end
  end

  assign l_o = r_i;
  assign r_o = l_i ^ perm_p(sbox_out);

endmodule

FILE: hw/rtl/des_block_cipher.sv
// des block cipher top level: key ring, round unit and handshake control
//
//   channel   signals                               direction
//   in        in_valid_i, in_stall_o, req_type_i,   request into block
//             data_block_i
//   out       out_valid_o, out_stall_i,             result out of block
//             result_block_o
//   cfg       cfg_we_i, cfg_wdata_i                 key register write
//
// one feistel round per cycle through a single round unit, save while the last
// round holds on a stalled result. the key schedule is two rings of 28 one-bit
// cells that rotate once per round, but not in the first round of a decrypt.
// a new request is taken in the cycle the last round retires, with no idle gap.
// reset clears the key register to zero and empties the block.
// while the result register is full and stalled, the last round holds.
module des_block_cipher (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [63:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        req_type_i,
  input  logic [63:0] data_block_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [63:0] result_block_o
);
  import des_pkg::*;

  logic [63:0] key_q;
  logic        busy_q, busy_d;
  logic [3:0]  round_q, round_d;
  logic        dec_q;
  logic [31:0] l_q, r_q, l_d, r_d;
  logic        out_valid_q, out_valid_d;
  logic [63:0] result_q;

  logic [55:0] cd_q, cd_rot, cd_load;
  des_kctl_t   kctl;
  logic [3:0]  rot_idx;
  logic        last, out_full, finish, accept;
  logic [63:0] blk_ip;

  assign last     = (round_q == 4'(NumRounds - 1));
  assign out_full = out_valid_q && out_stall_i;
  assign finish   = busy_q && last && !out_full;
  assign accept   = in_valid_i && !in_stall_o;

  assign in_stall_o = busy_q && !finish;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_q <= '0;
    end else if (cfg_we_i) begin
      key_q <= cfg_wdata_i;
    end
  end

  // decrypt walks the schedule backward: no shift in the first round
  assign rot_idx     = dec_q ? 4'(4'd0 - round_q) : round_q;
  assign kctl.load   = accept;
  assign kctl.step   = busy_q && !(last && out_full);
  assign kctl.shift  = !dec_q || (round_q != '0);
  assign kctl.left   = !dec_q;
  assign kctl.two    = RotTwo[rot_idx];
  assign cd_load     = perm_pc1(key_q);

  for (genvar h = 0; h < 2; h++) begin : g_half
    for (genvar j = 0; j < 28; j++) begin : g_cell
      localparam int Base = h * 28;
      des_key_cell u_cell (
        .clk_i      (clk_i),
        .ctl_i      (kctl),
        .load_bit_i (cd_load[Base + j]),
        .lo1_i      (cd_q[Base + (j + 27) % 28]),
        .lo2_i      (cd_q[Base + (j + 26) % 28]),
        .hi1_i      (cd_q[Base + (j + 1) % 28]),
        .hi2_i      (cd_q[Base + (j + 2) % 28]),
        .bit_o      (cd_q[Base + j]),
        .rot_o      (cd_rot[Base + j])
      );
    end
  end

  des_round u_round (
    .l_i      (l_q),
    .r_i      (r_q),
    .subkey_i (perm_pc2(cd_rot)),
    .l_o      (l_d),
    .r_o      (r_d)
  );

  assign blk_ip = perm_ip(data_block_i);

  always_comb begin
    busy_d  = busy_q;
    round_d = round_q;
    if (finish) begin
      busy_d = 1'b0;
    end else if (busy_q && !last) begin
      round_d = round_q + 4'd1;
    end
    if (accept) begin
      busy_d  = 1'b1;
      round_d = '0;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
    if (finish) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      round_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      busy_q      <= busy_d;
      round_q     <= round_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      dec_q <= req_type_i;
      l_q   <= blk_ip[63:32];
      r_q   <= blk_ip[31:0];
    end else if (busy_q && !last) begin
      l_q <= l_d;
      r_q <= r_d;
    end
    // final swap before the inverse permutation
    if (finish) begin
      result_q <= perm_ip_inv({r_d, l_d});
    end
  end

  assign out_valid_o    = out_valid_q;
  assign result_block_o = result_q;

  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> busy_q && (round_q == '0))
    else $error("request accepted but round counter not restarted");

  a_round_advance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy_q && !last && !accept) |=> busy_q && (round_q == 4'($past(round_q) + 4'd1)))
    else $error("round counter did not advance");

  a_result_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(busy_q) && ($past(round_q) == 4'(NumRounds - 1)))
    else $error("result shown before the last round");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_full |-> !finish)
    else $error("stalled result would be overwritten");

endmodule
